// ===== rtl/pln_pkg.sv =====
package pln_pkg;

  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_END  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NOP  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOT_ABS  = 2'd3;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  in_char;
    logic [11:0] read_index;
    logic        is_slash;
    logic        is_dot;
  } pln_item_t;

endpackage

// ===== rtl/pln_if.sv =====
interface pln_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  in_char;
  logic [11:0] read_index;

  modport source (output valid, output req_type, output in_char, output read_index,
                  input ready);
  modport sink (input valid, input req_type, input in_char, input read_index,
                output ready);
endinterface

interface pln_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] path_length;
  logic [7:0]  read_byte;

  modport source (output valid, output status, output path_length, output read_byte,
                  input ready);
  modport sink (input valid, input status, input path_length, input read_byte,
                output ready);
endinterface

// ===== rtl/path_lexical_normalizer.sv =====
// Lexical normaliser for absolute paths, fed one request per cycle while ready is high.
// The request channel carries path characters, end-of-path markers and
// read requests for bytes of the normalised path. Each request gives
// exactly one item on the result channel: the sticky status of the current
// or last path, the normalised length on end of path and the stored byte
// on a read.
// A request is accepted into a two-entry queue and moves from its head into
// the result register once that register is free or its item is taken.
// One request per cycle is sustained while the receiver takes every
// result; the rate is set by the single write port of the path buffer
// and by the top-of-stack register, which lets a '..' pop complete
// without stalling the requests. When the receiver stalls, the result
// register holds its item and the queue absorbs up to two further
// requests before ready falls. Reset clears the queue, the result valid
// flag and all path state, not the path buffer or the component stack;
// stack entries are used only once written; path bytes may be read unwritten.
module path_lexical_normalizer #(
  parameter int PATH_BYTES = 4096
) (
  input logic       clk,
  input logic       rst,
  pln_in_if.sink    request,
  pln_out_if.source result
);
  import pln_pkg::*;

  logic      q_valid;
  logic      q_pop;
  pln_item_t q_item;

  pln_front u_front (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pln_back #(.PATH_BYTES(PATH_BYTES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .result  (result)
  );
endmodule

// ===== rtl/pln_ram.sv =====
module pln_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/pln_front.sv =====
module pln_front (
  input  logic               clk,
  input  logic               rst,
  pln_in_if.sink             request,
  output logic               q_valid,
  output pln_pkg::pln_item_t q_item,
  input  logic               q_pop
);
  import pln_pkg::*;

  pln_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  pln_item_t  incoming;

  assign request.ready = (count != 2'd2);
  assign push = request.valid && request.ready;

  always_comb begin
    incoming.req_type   = request.req_type;
    incoming.in_char    = request.in_char;
    incoming.read_index = request.read_index;
    incoming.is_slash   = (request.in_char == CHAR_SLASH);
    incoming.is_dot     = (request.in_char == CHAR_DOT);
  end

  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

// ===== rtl/pln_back.sv =====
module pln_back #(
  parameter int PATH_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  pln_pkg::pln_item_t q_item,
  output logic               q_pop,
  pln_out_if.source          result
);
  import pln_pkg::*;

  localparam int AW  = $clog2(PATH_BYTES);
  localparam int CW  = $clog2(PATH_BYTES + 1);
  localparam int SW  = CW + 1;
  localparam int SD  = PATH_BYTES / 2;
  localparam int DW  = $clog2(SD + 1);
  localparam int SAW = $clog2(SD);

  logic          popen, popen_next;
  logic [DW-1:0] depth, depth_next;
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] tos, tos_next;
  logic [CW-1:0] seglen, seglen_next;
  logic [1:0]    dots, dots_next;
  logic [CW-1:0] icnt, icnt_next;
  logic [1:0]    err, err_next;

  logic          ov;
  logic [1:0]    o_status;
  logic [11:0]   o_len;
  logic          o_rd;

  logic           mwe, mre, in_range;
  logic [AW-1:0]  mwaddr;
  logic [7:0]     mwdata, mrdata;
  logic           swe;
  logic [SAW-1:0] sraddr;
  logic [AW-1:0]  srdata;
  logic [DW-1:0]  depth_less2;

  logic [SW-1:0] seg_end;
  logic          seg_kept, push_ok, do_seg, do_fin;
  logic [AW-1:0] fin_w;
  logic [AW-1:0] len_out;

  assign q_pop    = q_valid && (!ov || result.ready);
  assign seg_end  = SW'(wp) + SW'(seglen);
  assign seg_kept = (seglen != '0) && (dots != 2'd1);
  assign push_ok  = ((seg_end + SW'(1)) < SW'(PATH_BYTES)) && (depth < DW'(SD));
  assign mre      = q_pop && (q_item.req_type == REQ_READ);
  assign in_range = (32'(q_item.read_index) < 32'(PATH_BYTES));

  always_comb begin
    popen_next  = popen;
    depth_next  = depth;
    wp_next     = wp;
    tos_next    = tos;
    seglen_next = seglen;
    dots_next   = dots;
    icnt_next   = icnt;
    err_next    = err;
    mwe         = 1'b0;
    mwaddr      = '0;
    mwdata      = '0;
    swe         = 1'b0;
    do_seg      = 1'b0;
    do_fin      = 1'b0;
    fin_w       = '0;
    len_out     = '0;
    if (q_pop) begin
      case (q_item.req_type)
        REQ_CHAR: begin
          if (!popen) begin
            popen_next  = 1'b1;
            depth_next  = '0;
            wp_next     = AW'(1);
            seglen_next = '0;
            dots_next   = 2'd0;
            icnt_next   = CW'(1);
            err_next    = q_item.is_slash ? ST_OK : ST_NOT_ABS;
            mwe         = 1'b1;
            mwaddr      = '0;
            mwdata      = CHAR_SLASH;
          end else begin
            if (icnt < CW'(PATH_BYTES)) begin
              icnt_next = icnt + CW'(1);
            end
            if ((icnt_next >= CW'(PATH_BYTES)) && (err == ST_OK)) begin
              err_next = ST_TOO_LONG;
            end
            if (err_next == ST_OK) begin
              if (q_item.is_slash) begin
                do_seg = 1'b1;
              end else begin
                if (seg_end < SW'(PATH_BYTES)) begin
                  mwe    = 1'b1;
                  mwaddr = AW'(seg_end);
                  mwdata = q_item.in_char;
                end
                if (seglen < CW'(PATH_BYTES)) begin
                  seglen_next = seglen + CW'(1);
                end
                if (q_item.is_dot && (dots < 2'd2)) begin
                  dots_next = dots + 2'd1;
                end else begin
                  dots_next = 2'd3;
                end
              end
            end
          end
        end
        REQ_END: begin
          if (!popen) begin
            err_next = ST_EMPTY;
          end else begin
            popen_next = 1'b0;
            if (err == ST_OK) begin
              do_seg = 1'b1;
              do_fin = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (do_seg) begin
      seglen_next = '0;
      dots_next   = 2'd0;
      if (seg_kept) begin
        if (dots == 2'd2) begin
          if (depth != '0) begin
            depth_next = depth - DW'(1);
            wp_next    = tos;
            tos_next   = srdata;
          end
        end else if (!push_ok) begin
          err_next = ST_TOO_LONG;
        end else begin
          swe        = 1'b1;
          depth_next = depth + DW'(1);
          tos_next   = wp;
          wp_next    = AW'(seg_end + SW'(1));
          mwe        = 1'b1;
          mwaddr     = AW'(seg_end);
          mwdata     = CHAR_SLASH;
        end
      end
    end
    if (do_fin && (err_next == ST_OK)) begin
      fin_w   = (wp_next > AW'(1)) ? (wp_next - AW'(1)) : wp_next;
      mwe     = 1'b1;
      mwaddr  = fin_w;
      mwdata  = 8'h00;
      len_out = fin_w;
    end
  end

  assign depth_less2 = depth_next - DW'(2);
  assign sraddr      = SAW'(depth_less2);

  pln_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_path_ram (
    .clk   (clk),
    .we    (mwe),
    .waddr (mwaddr),
    .wdata (mwdata),
    .re    (mre),
    .raddr (AW'(q_item.read_index)),
    .rdata (mrdata)
  );

  pln_ram #(.WIDTH(AW), .DEPTH(SD)) u_stack_ram (
    .clk   (clk),
    .we    (swe),
    .waddr (SAW'(depth)),
    .wdata (wp),
    .re    (1'b1),
    .raddr (sraddr),
    .rdata (srdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      popen  <= 1'b0;
      depth  <= '0;
      wp     <= AW'(1);
      tos    <= '0;
      seglen <= '0;
      dots   <= 2'd0;
      icnt   <= '0;
      err    <= ST_OK;
      ov     <= 1'b0;
    end else begin
      popen  <= popen_next;
      depth  <= depth_next;
      wp     <= wp_next;
      tos    <= tos_next;
      seglen <= seglen_next;
      dots   <= dots_next;
      icnt   <= icnt_next;
      err    <= err_next;
      if (q_pop) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      o_status <= err_next;
      o_len    <= 12'(len_out);
      o_rd     <= mre && in_range;
    end
  end

  assign result.valid       = ov;
  assign result.status      = o_status;
  assign result.path_length = o_len;
  assign result.read_byte   = o_rd ? mrdata : 8'h00;
endmodule

// ===== rtl/pln_checker.sv =====
module pln_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [11:0] out_path_length,
  input logic [7:0]  out_read_byte
);
  import pln_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
      && $stable(out_path_length) && $stable(out_read_byte)))
    else $error("stalled result changed");

  a_err_no_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (out_path_length == 12'd0))
    else $error("length reported with an error status");

  a_len_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_path_length != 12'd0)) |-> (out_read_byte == 8'h00))
    else $error("byte reported on an end of path");
endmodule

bind path_lexical_normalizer pln_checker u_pln_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_status      (result.status),
  .out_path_length (result.path_length),
  .out_read_byte   (result.read_byte)
);

// ===== tb/pln_checker.sv =====
`timescale 1ns / 1ps

module pln_scoreboard (
  input  logic clk,
  input  logic rst,
  pln_in_if    req_ch,
  pln_out_if   res_ch,
  output int   fail_count,
  output int   pending,
  output int   stored_hi
);
  import pln_pkg::*;

  localparam int BUF_BYTES = 4096;
  localparam int STACK_MAX = BUF_BYTES / 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] path_length;
    logic [7:0]  read_byte;
  } outcome_t;

  outcome_t   outcome_q[$];
  logic [7:0] norm_buf [0:BUF_BYTES-1];
  int         comp_start [0:STACK_MAX-1];
  int         depth;
  int         wpos;
  int         seg_len;
  int         seg_dots;
  int         char_count;
  logic [1:0] path_err;
  bit         in_path;
  int         written_hi;
  int         fails;

  task automatic put_byte(input int pos, input logic [7:0] b);
    if (pos < BUF_BYTES) begin
      norm_buf[pos] = b;
      if (pos > written_hi) written_hi = pos;
    end
  endtask

  task automatic close_component();
    int len;
    int dots;
    len = seg_len;
    dots = seg_dots;
    seg_len = 0;
    seg_dots = 0;
    if (len == 0 || dots == 1) return;
    if (dots == 2) begin
      if (depth > 0) begin
        depth--;
        wpos = comp_start[depth] % BUF_BYTES;
      end
      return;
    end
    if (wpos + len + 1 >= BUF_BYTES || depth >= STACK_MAX) begin
      path_err = ST_TOO_LONG;
      return;
    end
    comp_start[depth] = wpos;
    depth++;
    put_byte(wpos + len, CHAR_SLASH);
    wpos = wpos + len + 1;
  endtask

  task automatic accept_char(input logic [7:0] c);
    if (!in_path) begin
      in_path = 1'b1;
      depth = 0;
      wpos = 1;
      seg_len = 0;
      seg_dots = 0;
      path_err = (c != CHAR_SLASH) ? ST_NOT_ABS : ST_OK;
      put_byte(0, CHAR_SLASH);
      char_count = 1;
      return;
    end
    if (char_count < BUF_BYTES) char_count++;
    if (char_count >= BUF_BYTES && path_err == ST_OK) path_err = ST_TOO_LONG;
    if (path_err != ST_OK) return;
    if (c == CHAR_SLASH) begin
      close_component();
      return;
    end
    put_byte(wpos + seg_len, c);
    if (seg_len < BUF_BYTES) seg_len++;
    if (c == CHAR_DOT && seg_dots < 2) seg_dots++;
    else seg_dots = 3;
  endtask

  task automatic normalise(input logic [1:0] kind, input logic [7:0] c,
                           input logic [11:0] idx, output outcome_t o);
    int w;
    o = '0;
    case (kind)
      REQ_CHAR: accept_char(c);
      REQ_END: begin
        if (!in_path) begin
          path_err = ST_EMPTY;
        end else begin
          if (path_err == ST_OK) close_component();
          if (path_err == ST_OK) begin
            w = wpos;
            if (w > 1) w--;
            put_byte(w, 8'h00);
            o.path_length = w[11:0];
          end
          in_path = 1'b0;
        end
      end
      REQ_READ: begin
        if (idx < BUF_BYTES) o.read_byte = norm_buf[idx];
      end
      default: ;
    endcase
    o.status = path_err;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      outcome_q.delete();
      depth = 0;
      wpos = 1;
      seg_len = 0;
      seg_dots = 0;
      char_count = 0;
      path_err = ST_OK;
      in_path = 1'b0;
      written_hi = -1;
      fails = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        normalise(req_ch.req_type, req_ch.in_char, req_ch.read_index, want);
        outcome_q.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.status, res_ch.path_length, res_ch.read_byte};
        if (outcome_q.size() == 0) begin
          if (fails < 10) $display("%0t: unexpected result %p", $realtime, got);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= outcome_q.size();
    stored_hi  <= written_hi;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pln_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   stored_hi;
  bit   calm;
  bit   hold_req;
  bit   hold_done;
  int   sent;

  pln_in_if  req_if ();
  pln_out_if res_if ();

  path_lexical_normalizer u_top (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  pln_scoreboard u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_ch     (req_if),
    .res_ch     (res_if),
    .fail_count (fail_count),
    .pending    (pending),
    .stored_hi  (stored_hi)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #3600000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int n;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [1:0] kind, input logic [7:0] c, input logic [11:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 6) == 0) begin
      req_if.valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.in_char    <= c;
    req_if.read_index <= idx;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send(REQ_CHAR, s[i], 12'd0);
  endtask

  task automatic send_read();
    if (stored_hi >= 0) send(REQ_READ, 8'h00, 12'($urandom_range(0, stored_hi)));
  endtask

  task automatic send_run(input int n, input logic [7:0] c);
    repeat (n) send(REQ_CHAR, c, 12'd0);
  endtask

  function automatic string name_part();
    string s;
    int    n;
    logic [7:0] c;
    s = "";
    case ($urandom_range(0, 7))
      0: s = "";
      1: s = ".";
      2: s = "..";
      3: s = "...";
      4: s = ".h";
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == CHAR_SLASH);
          if ($urandom_range(0, 5) == 0) c = CHAR_DOT;
          s = {s, string'(c)};
        end
      end
    endcase
    return s;
  endfunction

  initial begin
    int parts;
    int k;
    rst <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_CHAR;
    req_if.in_char    <= 8'h00;
    req_if.read_index <= 12'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send(REQ_END, 8'h00, 12'd0);
    send(REQ_NOP, 8'hFF, 12'hFFF);
    send_text("/a/./b/../c/");
    send(REQ_END, 8'h00, 12'd0);
    send(REQ_READ, 8'h00, 12'd0);
    send(REQ_READ, 8'h00, 12'd2);
    send_text("/../..");
    send(REQ_END, 8'h00, 12'd0);
    send_text("x");
    send(REQ_END, 8'h00, 12'd0);
    send(REQ_CHAR, CHAR_SLASH, 12'd0);
    send(REQ_CHAR, 8'h00, 12'd0);
    send(REQ_CHAR, 8'hFF, 12'd0);
    send(REQ_END, 8'h00, 12'd0);
    send(REQ_READ, 8'h00, 12'd1);
    send(REQ_END, 8'h00, 12'd0);

    hold_req <= 1'b1;
    send(REQ_CHAR, CHAR_SLASH, 12'd0);
    send_run(40, 8'h61);
    send(REQ_END, 8'h00, 12'd0);
    send(REQ_READ, 8'h00, 12'd40);
    send(REQ_READ, 8'h00, 12'd20);

    while (sent < 850) begin
      if (sent > 750) calm <= 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        send(REQ_CHAR, CHAR_SLASH, 12'd0);
        parts = $urandom_range(1, 6);
        for (k = 0; k < parts; k++) begin
          send_text(name_part());
          if (k < parts - 1 || $urandom_range(0, 1) == 0) send(REQ_CHAR, CHAR_SLASH, 12'd0);
        end
        send(REQ_END, 8'h00, 12'd0);
        repeat ($urandom_range(0, 3)) send_read();
      end else begin
        case ($urandom_range(0, 3))
          0: send(REQ_CHAR, 8'($urandom_range(0, 255)), 12'd0);
          1: send(REQ_END, 8'h00, 12'd0);
          2: send_read();
          default: send(REQ_NOP, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
        endcase
      end
    end

    req_if.valid <= 1'b0;
    k = 0;
    while (pending != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pln_pkg.sv
rtl/pln_if.sv
rtl/pln_ram.sv
rtl/pln_front.sv
rtl/pln_back.sv
rtl/path_lexical_normalizer.sv
rtl/pln_checker.sv
tb/pln_checker.sv
tb/tb_top.sv
